// ===== rtl/core/pid3_pkg.sv =====
`default_nettype none

package pid3_pkg;

	// Sizes of the item fields and registers
	localparam int AXES_DEF = 3;
	localparam int AXIS_W   = 2;
	localparam int RATE_W   = 16;
	localparam int GAIN_W   = 20;
	localparam int GAINS_W  = 60;
	localparam int LIM_W    = 14;
	localparam int LPF_W    = 32;
	localparam int COEF_W   = 16;
	localparam int PT_W     = 16;
	localparam int TERM_W   = 15;
	localparam int STATE_W  = 32;

	// APB register port
	localparam int APB_AW  = 6;
	localparam int APB_DW  = 64;
	localparam int IDX_LSB = 3;

	// Register reset values
	localparam logic [LIM_W-1:0] ITERM_LIM_RST = 14'd8000;
	localparam logic [LIM_W-1:0] DTERM_LIM_RST = 14'd12800;
	localparam logic [LIM_W-1:0] SUM_LIM_RST   = 14'd16000;
	localparam logic [LPF_W-1:0] LPF_RST       = 32'd253954478;

	// Register indexes (byte address = 8 * index)
	typedef enum logic [APB_AW-IDX_LSB-1:0] {
		REG_KP    = 3'd0,
		REG_KI    = 3'd1,
		REG_KD    = 3'd2,
		REG_KF    = 3'd3,
		REG_ILIM  = 3'd4,
		REG_DLIM  = 3'd5,
		REG_SLIM  = 3'd6,
		REG_LPF   = 3'd7
	} reg_idx_t;

	// Operand selection for the shared multiplier
	typedef enum logic [2:0] {
		MUL_P  = 3'd0,
		MUL_I  = 3'd1,
		MUL_D  = 3'd2,
		MUL_F  = 3'd3,
		MUL_L1 = 3'd4,
		MUL_L2 = 3'd5
	} mul_sel_t;

	typedef struct packed {
		logic [GAINS_W-1:0] kp;
		logic [GAINS_W-1:0] ki;
		logic [GAINS_W-1:0] kd;
		logic [GAINS_W-1:0] kf;
		logic [LIM_W-1:0]   iterm_lim;
		logic [LIM_W-1:0]   dterm_lim;
		logic [LIM_W-1:0]   sum_lim;
		logic [LPF_W-1:0]   lpf;
	} cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic     capture;
		logic     clear_int;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     fin_p;
		logic     fin_i;
		logic     fin_raw;
		logic     fin_f;
		logic     fin_l1;
		logic     fin_l2;
		logic     fin_d;
		logic     load_out;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;
	} sts_t;

	// Per-axis gain from a packed gain register; axes past the register see zero
	function automatic logic [GAIN_W-1:0] gain_sel(input logic [GAINS_W-1:0] gains,
			input logic [AXIS_W-1:0] ax);
		logic [GAIN_W-1:0] g;
		case (ax)
			2'd0: g = gains[GAIN_W-1:0];
			2'd1: g = gains[2*GAIN_W-1:GAIN_W];
			2'd2: g = gains[3*GAIN_W-1:2*GAIN_W];
			default: g = '0;
		endcase
		return g;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pid3_if.sv =====
`default_nettype none

// Apply / clear item channel
interface pid3_in_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  op;
	logic        [pid3_pkg::AXIS_W-1:0]    axis;
	logic signed [pid3_pkg::RATE_W-1:0]    gyro_rate;
	logic signed [pid3_pkg::RATE_W-1:0]    setpoint;

	modport source (output valid, op, axis, gyro_rate, setpoint, input ready);
	modport sink (input valid, op, axis, gyro_rate, setpoint, output ready);
endinterface

// Result item channel
interface pid3_out_if;
	logic                                  valid;
	logic                                  ready;
	logic        [pid3_pkg::AXIS_W-1:0]    out_axis;
	logic signed [pid3_pkg::PT_W-1:0]      p_term;
	logic signed [pid3_pkg::TERM_W-1:0]    i_term;
	logic signed [pid3_pkg::TERM_W-1:0]    d_term;
	logic signed [pid3_pkg::PT_W-1:0]      f_term;
	logic signed [pid3_pkg::TERM_W-1:0]    pid_sum;

	modport source (output valid, out_axis, p_term, i_term, d_term, f_term, pid_sum,
		input ready);
	modport sink (input valid, out_axis, p_term, i_term, d_term, f_term, pid_sum,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pid3_regs.sv =====
`default_nettype none

module pid3_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pid3_pkg::APB_AW-1:0]   paddr,
	input  logic [pid3_pkg::APB_DW-1:0]   pwdata,
	output logic [pid3_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	output pid3_pkg::cfg_t                cfg
);

	pid3_pkg::cfg_t     cfg_q;
	pid3_pkg::reg_idx_t idx;
	logic               wr;

	assign pready = 1'b1;
	assign idx    = pid3_pkg::reg_idx_t'(paddr[pid3_pkg::APB_AW-1:pid3_pkg::IDX_LSB]);
	assign wr     = psel & penable & pwrite;
	assign cfg    = cfg_q;

	// Register writes in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp        <= '0;
			cfg_q.ki        <= '0;
			cfg_q.kd        <= '0;
			cfg_q.kf        <= '0;
			cfg_q.iterm_lim <= pid3_pkg::ITERM_LIM_RST;
			cfg_q.dterm_lim <= pid3_pkg::DTERM_LIM_RST;
			cfg_q.sum_lim   <= pid3_pkg::SUM_LIM_RST;
			cfg_q.lpf       <= pid3_pkg::LPF_RST;
		end else if (wr) begin
			case (idx)
				pid3_pkg::REG_KP:   cfg_q.kp <= pwdata[pid3_pkg::GAINS_W-1:0];
				pid3_pkg::REG_KI:   cfg_q.ki <= pwdata[pid3_pkg::GAINS_W-1:0];
				pid3_pkg::REG_KD:   cfg_q.kd <= pwdata[pid3_pkg::GAINS_W-1:0];
				pid3_pkg::REG_KF:   cfg_q.kf <= pwdata[pid3_pkg::GAINS_W-1:0];
				pid3_pkg::REG_ILIM: cfg_q.iterm_lim <= pwdata[pid3_pkg::LIM_W-1:0];
				pid3_pkg::REG_DLIM: cfg_q.dterm_lim <= pwdata[pid3_pkg::LIM_W-1:0];
				pid3_pkg::REG_SLIM: cfg_q.sum_lim <= pwdata[pid3_pkg::LIM_W-1:0];
				pid3_pkg::REG_LPF:  cfg_q.lpf <= pwdata[pid3_pkg::LPF_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (idx)
			pid3_pkg::REG_KP:   prdata = pid3_pkg::APB_DW'(cfg_q.kp);
			pid3_pkg::REG_KI:   prdata = pid3_pkg::APB_DW'(cfg_q.ki);
			pid3_pkg::REG_KD:   prdata = pid3_pkg::APB_DW'(cfg_q.kd);
			pid3_pkg::REG_KF:   prdata = pid3_pkg::APB_DW'(cfg_q.kf);
			pid3_pkg::REG_ILIM: prdata = pid3_pkg::APB_DW'(cfg_q.iterm_lim);
			pid3_pkg::REG_DLIM: prdata = pid3_pkg::APB_DW'(cfg_q.dterm_lim);
			pid3_pkg::REG_SLIM: prdata = pid3_pkg::APB_DW'(cfg_q.sum_lim);
			pid3_pkg::REG_LPF:  prdata = pid3_pkg::APB_DW'(cfg_q.lpf);
			default:            prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/pid3_ctrl.sv =====
`default_nettype none

module pid3_ctrl #(
	parameter int AXES = pid3_pkg::AXES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_op,
	input  logic [pid3_pkg::AXIS_W-1:0]  in_axis,
	output logic                         in_ready,
	input  pid3_pkg::sts_t               sts,
	output pid3_pkg::cmd_t               cmd
);

	typedef enum logic [10:0] {
		ST_IDLE = 11'b00000000001,
		ST_P    = 11'b00000000010,
		ST_I    = 11'b00000000100,
		ST_D    = 11'b00000001000,
		ST_F    = 11'b00000010000,
		ST_L1   = 11'b00000100000,
		ST_FL1  = 11'b00001000000,
		ST_L2   = 11'b00010000000,
		ST_FL2  = 11'b00100000000,
		ST_DT   = 11'b01000000000,
		ST_SUM  = 11'b10000000000
	} state_t;

	localparam int AXC_W = pid3_pkg::AXIS_W + 1;

	state_t state_q, state_d;
	logic   axis_ok;

	assign axis_ok  = {1'b0, in_axis} < AXC_W'(AXES);
	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequence: six passes through the multiplier, then D clamp and sum
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.mul_sel = pid3_pkg::MUL_P;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_op) begin
						cmd.clear_int = 1'b1;
					end else if (axis_ok) begin
						cmd.capture = 1'b1;
						state_d     = ST_P;
					end
				end
			end
			ST_P: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = pid3_pkg::MUL_P;
				state_d     = ST_I;
			end
			ST_I: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = pid3_pkg::MUL_I;
				cmd.fin_p   = 1'b1;
				state_d     = ST_D;
			end
			ST_D: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = pid3_pkg::MUL_D;
				cmd.fin_i   = 1'b1;
				state_d     = ST_F;
			end
			ST_F: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = pid3_pkg::MUL_F;
				cmd.fin_raw = 1'b1;
				state_d     = ST_L1;
			end
			ST_L1: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = pid3_pkg::MUL_L1;
				cmd.fin_f   = 1'b1;
				state_d     = ST_FL1;
			end
			ST_FL1: begin
				cmd.fin_l1 = 1'b1;
				state_d    = ST_L2;
			end
			ST_L2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = pid3_pkg::MUL_L2;
				state_d     = ST_FL2;
			end
			ST_FL2: begin
				cmd.fin_l2 = 1'b1;
				state_d    = ST_DT;
			end
			ST_DT: begin
				cmd.fin_d = 1'b1;
				state_d   = ST_SUM;
			end
			ST_SUM: begin
				// wait for the output register to free up
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/pid3_dp.sv =====
`default_nettype none

module pid3_dp #(
	parameter int AXES = pid3_pkg::AXES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pid3_pkg::cmd_t                      cmd,
	output pid3_pkg::sts_t                      sts,
	input  pid3_pkg::cfg_t                      cfg,
	input  logic        [pid3_pkg::AXIS_W-1:0]  in_axis,
	input  logic signed [pid3_pkg::RATE_W-1:0]  in_gyro,
	input  logic signed [pid3_pkg::RATE_W-1:0]  in_setpoint,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic        [pid3_pkg::AXIS_W-1:0]  out_axis,
	output logic signed [pid3_pkg::PT_W-1:0]    p_term,
	output logic signed [pid3_pkg::TERM_W-1:0]  i_term,
	output logic signed [pid3_pkg::TERM_W-1:0]  d_term,
	output logic signed [pid3_pkg::PT_W-1:0]    f_term,
	output logic signed [pid3_pkg::TERM_W-1:0]  pid_sum
);

	localparam int IW     = (AXES > 1) ? $clog2(AXES) : 1;
	localparam int DIFF_W = pid3_pkg::RATE_W + 1;
	localparam int OPA_W  = pid3_pkg::STATE_W + 1;
	localparam int OPB_W  = pid3_pkg::GAIN_W + 1;
	localparam int PROD_W = OPA_W + OPB_W;
	localparam int ACC_W  = 40;
	localparam int SUM_W  = pid3_pkg::PT_W + 2;
	localparam int SW     = pid3_pkg::STATE_W;

	// Rounding offsets (half an LSB of the shifted result)
	localparam logic signed [PROD_W-1:0] HALF_P  = PROD_W'(1) << 10;
	localparam logic signed [PROD_W-1:0] HALF_I  = PROD_W'(1) << 2;
	localparam logic signed [PROD_W-1:0] HALF_D  = PROD_W'(1);
	localparam logic signed [PROD_W-1:0] HALF_F  = PROD_W'(1) << 8;
	localparam logic signed [PROD_W-1:0] HALF_L  = PROD_W'(1) << 15;
	localparam logic signed [SW:0]       HALF_IT = (SW+1)'(1) << 15;
	localparam logic signed [SW:0]       HALF_DT = (SW+1)'(1) << 7;

	// Saturation bounds
	localparam logic signed [PROD_W-1:0] PT_MAX = PROD_W'((1 << (pid3_pkg::PT_W-1)) - 1);
	localparam logic signed [PROD_W-1:0] PT_MIN = -PT_MAX - PROD_W'(1);
	localparam logic signed [PROD_W-1:0] RAW_MAX = PROD_W'((64'd1 << (SW-1)) - 64'd1);
	localparam logic signed [PROD_W-1:0] RAW_MIN = -RAW_MAX - PROD_W'(1);

	function automatic logic signed [pid3_pkg::PT_W-1:0] sat_pt(
			input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] r;
		if (v > PT_MAX) begin
			r = PT_MAX;
		end else if (v < PT_MIN) begin
			r = PT_MIN;
		end else begin
			r = v;
		end
		return r[pid3_pkg::PT_W-1:0];
	endfunction

	// Per-axis state
	logic signed [SW-1:0]              integ_q [AXES];
	logic signed [pid3_pkg::RATE_W-1:0] lgyro_q [AXES];
	logic signed [pid3_pkg::RATE_W-1:0] lsp_q   [AXES];
	logic signed [SW-1:0]              lpf1_q  [AXES];
	logic signed [SW-1:0]              lpf2_q  [AXES];

	// Working registers of the current item
	logic        [pid3_pkg::AXIS_W-1:0] axis_q;
	logic signed [DIFF_W-1:0]           err_q, dg_q, dsp_q;
	logic signed [PROD_W-1:0]           prod_q;
	logic signed [pid3_pkg::PT_W-1:0]   p_q, f_q;
	logic signed [pid3_pkg::TERM_W-1:0] it_q, d_q;
	logic signed [SW-1:0]               raw_q, f1_q, s2_q;

	// Output register
	logic                               out_valid_q;
	logic        [pid3_pkg::AXIS_W-1:0] o_axis_q;
	logic signed [pid3_pkg::PT_W-1:0]   o_p_q, o_f_q;
	logic signed [pid3_pkg::TERM_W-1:0] o_i_q, o_d_q, o_sum_q;

	logic [IW-1:0]                 ax, ain;
	logic [pid3_pkg::GAIN_W-1:0]   kp_g, ki_g, kd_g, kf_g;
	logic signed [OPA_W-1:0]       opa;
	logic signed [OPB_W-1:0]       opb;
	logic signed [PROD_W-1:0]      prod;
	logic signed [PROD_W-1:0]      sh_p, sh_i, sh_d, sh_f, sh_l;
	logic signed [ACC_W-1:0]       acc, acc_c, ilim;
	logic signed [SW-1:0]          raw_c, s1_n, s2_n;
	logic signed [SW:0]            it_sh, d_sh, dlim, d_c;
	logic signed [SUM_W-1:0]       sum, slim, sum_c;

	assign ax  = axis_q[IW-1:0];
	assign ain = in_axis[IW-1:0];

	assign kp_g = pid3_pkg::gain_sel(cfg.kp, axis_q);
	assign ki_g = pid3_pkg::gain_sel(cfg.ki, axis_q);
	assign kd_g = pid3_pkg::gain_sel(cfg.kd, axis_q);
	assign kf_g = pid3_pkg::gain_sel(cfg.kf, axis_q);

	// Shared multiplier operand select
	always_comb begin
		opa = '0;
		opb = '0;
		case (cmd.mul_sel)
			pid3_pkg::MUL_P: begin
				opa = OPA_W'(err_q);
				opb = OPB_W'(kp_g);
			end
			pid3_pkg::MUL_I: begin
				opa = OPA_W'(err_q);
				opb = OPB_W'(ki_g);
			end
			pid3_pkg::MUL_D: begin
				opa = OPA_W'(dg_q);
				opb = OPB_W'(kd_g);
			end
			pid3_pkg::MUL_F: begin
				opa = OPA_W'(dsp_q);
				opb = OPB_W'(kf_g);
			end
			pid3_pkg::MUL_L1: begin
				opa = OPA_W'(raw_q) - OPA_W'(lpf1_q[ax]);
				opb = OPB_W'(cfg.lpf[pid3_pkg::COEF_W-1:0]);
			end
			pid3_pkg::MUL_L2: begin
				opa = OPA_W'(f1_q) - OPA_W'(lpf2_q[ax]);
				opb = OPB_W'(cfg.lpf[pid3_pkg::LPF_W-1:pid3_pkg::COEF_W]);
			end
			default: ;
		endcase
	end

	assign prod = opa * opb;

	// Rounded shifts of the registered product
	assign sh_p = (prod_q + HALF_P) >>> 11;
	assign sh_i = (prod_q + HALF_I) >>> 3;
	assign sh_d = (prod_q + HALF_D) >>> 1;
	assign sh_f = (prod_q + HALF_F) >>> 9;
	assign sh_l = (prod_q + HALF_L) >>> 16;

	// Integrator update with clamp
	assign ilim = ACC_W'({cfg.iterm_lim, 16'd0});
	assign acc  = ACC_W'(integ_q[ax]) + $signed(sh_i[ACC_W-1:0]);
	always_comb begin
		if (acc > ilim) begin
			acc_c = ilim;
		end else if (acc < -ilim) begin
			acc_c = -ilim;
		end else begin
			acc_c = acc;
		end
	end

	// Raw derivative clamp to 32 bits
	always_comb begin
		if (sh_d > RAW_MAX) begin
			raw_c = RAW_MAX[SW-1:0];
		end else if (sh_d < RAW_MIN) begin
			raw_c = RAW_MIN[SW-1:0];
		end else begin
			raw_c = sh_d[SW-1:0];
		end
	end

	// Lowpass stage updates
	assign s1_n = lpf1_q[ax] + sh_l[SW-1:0];
	assign s2_n = lpf2_q[ax] + sh_l[SW-1:0];

	// I term from the stored integrator
	assign it_sh = ((SW+1)'(integ_q[ax]) + HALF_IT) >>> 16;

	// D term round and clamp
	assign d_sh = ((SW+1)'(s2_q) + HALF_DT) >>> 8;
	assign dlim = (SW+1)'(cfg.dterm_lim);
	always_comb begin
		if (d_sh > dlim) begin
			d_c = dlim;
		end else if (d_sh < -dlim) begin
			d_c = -dlim;
		end else begin
			d_c = d_sh;
		end
	end

	// Final sum and clamp
	assign sum  = SUM_W'(p_q) + SUM_W'(it_q) + SUM_W'(d_q) + SUM_W'(f_q);
	assign slim = SUM_W'(cfg.sum_lim);
	always_comb begin
		if (sum > slim) begin
			sum_c = slim;
		end else if (sum < -slim) begin
			sum_c = -slim;
		end else begin
			sum_c = sum;
		end
	end

	// Per-axis state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXES; i++) begin
				integ_q[i] <= '0;
				lgyro_q[i] <= '0;
				lsp_q[i]   <= '0;
				lpf1_q[i]  <= '0;
				lpf2_q[i]  <= '0;
			end
		end else begin
			if (cmd.clear_int) begin
				for (int i = 0; i < AXES; i++) begin
					integ_q[i] <= '0;
				end
			end
			if (cmd.capture) begin
				lgyro_q[ain] <= in_gyro;
				lsp_q[ain]   <= in_setpoint;
			end
			if (cmd.fin_i) begin
				integ_q[ax] <= acc_c[SW-1:0];
			end
			if (cmd.fin_l1) begin
				lpf1_q[ax] <= s1_n;
			end
			if (cmd.fin_l2) begin
				lpf2_q[ax] <= s2_n;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			axis_q <= in_axis;
			err_q  <= DIFF_W'(in_setpoint) - DIFF_W'(in_gyro);
			dg_q   <= DIFF_W'(lgyro_q[ain]) - DIFF_W'(in_gyro);
			dsp_q  <= DIFF_W'(in_setpoint) - DIFF_W'(lsp_q[ain]);
		end
		if (cmd.mul_en) begin
			prod_q <= prod;
		end
		if (cmd.fin_p) begin
			p_q <= sat_pt(sh_p);
		end
		if (cmd.fin_raw) begin
			raw_q <= raw_c;
			it_q  <= it_sh[pid3_pkg::TERM_W-1:0];
		end
		if (cmd.fin_f) begin
			f_q <= sat_pt(sh_f);
		end
		if (cmd.fin_l1) begin
			f1_q <= s1_n;
		end
		if (cmd.fin_l2) begin
			s2_q <= s2_n;
		end
		if (cmd.fin_d) begin
			d_q <= d_c[pid3_pkg::TERM_W-1:0];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			o_axis_q <= axis_q;
			o_p_q    <= p_q;
			o_i_q    <= it_q;
			o_d_q    <= d_q;
			o_f_q    <= f_q;
			o_sum_q  <= sum_c[pid3_pkg::TERM_W-1:0];
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_axis  = o_axis_q;
	assign p_term    = o_p_q;
	assign i_term    = o_i_q;
	assign d_term    = o_d_q;
	assign f_term    = o_f_q;
	assign pid_sum   = o_sum_q;

endmodule

`default_nettype wire

// ===== rtl/core/three_axis_pid_with_dterm_filter_top.sv =====
`default_nettype none

// Three-axis rate PID with a twice-lowpassed measurement derivative and setpoint
// feedforward, in fixed point. An apply item (op 0) runs one axis and returns
// its P, I, D and F terms and their clamped sum; a clear item (op 1) zeroes
// every integrator and returns nothing, as does an apply whose axis is not
// below AXES. No new item is accepted until an apply item is done, and
// inside it one 33x21-bit multiplier is shared by the six
// products (P, I, D, F and both filter stages), each registered and then
// rounded, followed by the D clamp and the sum; the result sits in an output
// register, and an item is held back only while that register is still full
// at the end of the sequence. Registers sit on a 64-bit APB port at byte
// address 8*index: 0 kp, 1 ki, 2 kd, 3 kf (three 20-bit gains each, axis 0
// in the low bits), 4 iterm_limit, 5 dterm_limit, 6 sum_limit, 7 lpf_gains.
// Write them only while the block is idle.
module three_axis_pid_with_dterm_filter_top #(
	parameter int AXES = pid3_pkg::AXES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pid3_pkg::APB_AW-1:0]  paddr,
	input  logic [pid3_pkg::APB_DW-1:0]  pwdata,
	output logic [pid3_pkg::APB_DW-1:0]  prdata,
	output logic                         pready,
	pid3_in_if.sink                      pid_in,
	pid3_out_if.source                   pid_out
);

	pid3_pkg::cfg_t cfg;
	pid3_pkg::cmd_t cmd;
	pid3_pkg::sts_t sts;

	// Configuration registers
	pid3_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer
	pid3_ctrl #(
		.AXES (AXES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pid_in.valid),
		.in_op    (pid_in.op),
		.in_axis  (pid_in.axis),
		.in_ready (pid_in.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Arithmetic and per-axis state
	pid3_dp #(
		.AXES (AXES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg         (cfg),
		.in_axis     (pid_in.axis),
		.in_gyro     (pid_in.gyro_rate),
		.in_setpoint (pid_in.setpoint),
		.out_valid   (pid_out.valid),
		.out_ready   (pid_out.ready),
		.out_axis    (pid_out.out_axis),
		.p_term      (pid_out.p_term),
		.i_term      (pid_out.i_term),
		.d_term      (pid_out.d_term),
		.f_term      (pid_out.f_term),
		.pid_sum     (pid_out.pid_sum)
	);

`ifndef NO_ASSERTIONS
	// A clear item never produces a result
	a_clear_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		pid_in.valid && pid_in.ready && pid_in.op |=> !$rose(pid_out.valid))
		else $error("result raised after a clear item");

	// Results only carry axes that exist
	a_axis_range: assert property (@(posedge clk) disable iff (!arst_n)
		pid_out.valid |-> ({1'b0, pid_out.out_axis} < (pid3_pkg::AXIS_W+1)'(AXES)))
		else $error("result for an axis out of range");

	// A new result is only loaded at the end of a busy sequence
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pid_out.valid) |-> $past(!pid_in.ready))
		else $error("result raised while the block was idle");
`endif

endmodule

`default_nettype wire
